FILE: rtl/ilsp_pkg.sv
// Shared types, constants and codes for the indentation line parser.
package ilsp_pkg;

   // Sizing
   localparam int LEVEL_DEPTH = 16;
   localparam int LEVEL_W     = (LEVEL_DEPTH > 1) ? $clog2(LEVEL_DEPTH) : 1;
   // Tab stop, a power of two so the column remainder is a mask
   localparam int TAB_STOP    = 8;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int HDR_LEN     = 10;

   localparam logic [11:0] INDENT_MAX = 12'hFFF;
   localparam logic [15:0] BYTES_MAX  = 16'hFFFF;

   // Characters
   localparam logic [20:0] CH_NEWLINE = 21'h00000A;
   localparam logic [20:0] CH_TAB     = 21'h000009;
   localparam logic [20:0] CH_SPACE   = 21'h000020;
   localparam logic [20:0] MAGIC_CHARS [4] = '{21'h63, 21'h67, 21'h6D, 21'h31};

   // Input kinds
   localparam logic [1:0] KIND_VALID = 2'd0;
   localparam logic [1:0] KIND_EOD   = 2'd2;

   // Result status codes
   localparam logic [2:0] ST_LINE       = 3'd0;
   localparam logic [2:0] ST_EMPTY      = 3'd1;
   localparam logic [2:0] ST_END        = 3'd2;
   localparam logic [2:0] ST_BAD_HEADER = 3'd3;
   localparam logic [2:0] ST_HDR_GARB   = 3'd4;
   localparam logic [2:0] ST_INVALID    = 3'd5;
   localparam logic [2:0] ST_MISMATCH   = 3'd6;
   localparam logic [2:0] ST_TOO_DEEP   = 3'd7;

   typedef struct packed {
      logic [20:0] code_point;
      logic [2:0]  code_bytes;
      logic [1:0]  code_kind;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [11:0] line_indent;
      logic [3:0]  nest_depth;
      logic [15:0] text_bytes;
      logic        at_end;
   } rsp_type;

   // Classified command handed from front to back
   typedef enum logic [2:0] {
      OP_SPACE,
      OP_TAB,
      OP_NEWLINE,
      OP_CHAR,
      OP_EOD,
      OP_BAD,
      OP_HDR_BAD,
      OP_HDR_GARBAGE
   } cmd_op_type;

   typedef struct packed {
      cmd_op_type  op;
      logic [2:0]  nbytes;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic valid;
   } q_stat_type;

   typedef enum logic [1:0] {
      FR_HEADER,
      FR_BODY,
      FR_STOP
   } front_state_type;

   typedef enum logic [1:0] {
      BK_INDENT,
      BK_TEXT,
      BK_DONE
   } back_state_type;

endpackage

FILE: rtl/ilsp_front.sv
// Front end: header check and classification of each request into a command.
module ilsp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ilsp_pkg::req_type   req_payload,
   input  ilsp_pkg::q_stat_type q_stat,
   output logic                push,
   output ilsp_pkg::cmd_type   push_cmd
);

   ilsp_pkg::front_state_type state_ff, state_in;
   logic [3:0]                hdr_pos_ff, hdr_pos_in;
   logic                      accept;
   logic                      is_valid;
   logic                      is_eod;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign is_valid  = (req_payload.code_kind == ilsp_pkg::KIND_VALID);
   assign is_eod    = (req_payload.code_kind == ilsp_pkg::KIND_EOD);

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ilsp_pkg::FR_HEADER;
         hdr_pos_ff <= 4'd0;
      end else begin
         state_ff   <= state_in;
         hdr_pos_ff <= hdr_pos_in;
      end
   end

   // Classification and header walk
   always_comb begin
      state_in        = state_ff;
      hdr_pos_in      = hdr_pos_ff;
      push            = 1'b0;
      push_cmd.op     = ilsp_pkg::OP_BAD;
      push_cmd.nbytes = req_payload.code_bytes;
      case (state_ff)
         ilsp_pkg::FR_HEADER: begin
            if (accept) begin
               hdr_pos_in = hdr_pos_ff + 4'd1;
               if (hdr_pos_ff >= 4'd1 && hdr_pos_ff <= 4'd4) begin
                  if (!is_valid ||
                      req_payload.code_point != ilsp_pkg::MAGIC_CHARS[2'(hdr_pos_ff - 4'd1)]) begin
                     push        = 1'b1;
                     push_cmd.op = ilsp_pkg::OP_HDR_BAD;
                  end
               end else if (hdr_pos_ff == 4'(ilsp_pkg::HDR_LEN - 1)) begin
                  if (!is_valid || req_payload.code_point != ilsp_pkg::CH_NEWLINE) begin
                     push        = 1'b1;
                     push_cmd.op = ilsp_pkg::OP_HDR_GARBAGE;
                  end
               end else if (is_eod) begin
                  push        = 1'b1;
                  push_cmd.op = (hdr_pos_ff == 4'd0) ? ilsp_pkg::OP_HDR_BAD
                                                     : ilsp_pkg::OP_HDR_GARBAGE;
               end
               if (push) begin
                  state_in = ilsp_pkg::FR_STOP;
               end else if (hdr_pos_ff == 4'(ilsp_pkg::HDR_LEN - 1)) begin
                  state_in = ilsp_pkg::FR_BODY;
               end
            end
         end
         ilsp_pkg::FR_BODY: begin
            push = accept;
            if (is_eod) begin
               push_cmd.op = ilsp_pkg::OP_EOD;
            end else if (!is_valid) begin
               push_cmd.op = ilsp_pkg::OP_BAD;
            end else if (req_payload.code_point == ilsp_pkg::CH_NEWLINE) begin
               push_cmd.op = ilsp_pkg::OP_NEWLINE;
            end else if (req_payload.code_point == ilsp_pkg::CH_SPACE) begin
               push_cmd.op = ilsp_pkg::OP_SPACE;
            end else if (req_payload.code_point == ilsp_pkg::CH_TAB) begin
               push_cmd.op = ilsp_pkg::OP_TAB;
            end else begin
               push_cmd.op = ilsp_pkg::OP_CHAR;
            end
         end
         ilsp_pkg::FR_STOP: begin
            // header failed: drop everything
            push = 1'b0;
         end
         default: begin
            state_in = ilsp_pkg::FR_STOP;
         end
      endcase
   end

endmodule

FILE: rtl/ilsp_queue.sv
// Short command queue between the front end and the back end.
module ilsp_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  ilsp_pkg::cmd_type    push_cmd,
   input  logic                 pop,
   output ilsp_pkg::cmd_type    head_cmd,
   output ilsp_pkg::q_stat_type q_stat
);

   ilsp_pkg::cmd_type                  mem_ff [ilsp_pkg::QUEUE_DEPTH];
   logic [ilsp_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ilsp_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ilsp_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                              do_push;
   logic                              do_pop;

   assign q_stat.full  = (count_ff == ilsp_pkg::QCNT_W'(ilsp_pkg::QUEUE_DEPTH));
   assign q_stat.valid = (count_ff != '0);
   assign head_cmd     = mem_ff[rd_ptr_ff];
   assign do_push      = push && !q_stat.full;
   assign do_pop       = pop && q_stat.valid;

   // Pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == ilsp_pkg::QPTR_W'(ilsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + ilsp_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == ilsp_pkg::QPTR_W'(ilsp_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + ilsp_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + ilsp_pkg::QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - ilsp_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

FILE: rtl/ilsp_back.sv
// Back end: indent measurement, level stack and result register.
module ilsp_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ilsp_pkg::q_stat_type q_stat,
   input  ilsp_pkg::cmd_type    head_cmd,
   output logic                 pop,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output ilsp_pkg::rsp_type    rsp_payload
);

   localparam int LW = ilsp_pkg::LEVEL_W;
   localparam int LD = ilsp_pkg::LEVEL_DEPTH;

   ilsp_pkg::back_state_type state_ff, state_in;
   logic [11:0]              indent_ff, indent_in;
   logic [15:0]              bytes_ff, bytes_in;
   logic [LW-1:0]            level_ff, level_in;
   logic [11:0]              stack_ff [LD];
   logic [11:0]              stack_in [LD];
   logic                     rsp_valid_ff, rsp_valid_in;
   ilsp_pkg::rsp_type        rsp_ff, rsp_in;

   logic                     fire;
   logic                     emit;
   logic [LD-1:0]            in_range;
   logic [LD-1:0]            lt_vec;
   logic [LD-1:0]            le_vec;
   logic [LD-1:0]            eq_vec;
   logic                     grow;
   logic                     hit;
   logic [LW-1:0]            new_level;
   logic [12:0]              space_sum;
   logic [12:0]              tab_sum;
   logic [16:0]              byte_sum;

   assign fire        = q_stat.valid && (!rsp_valid_ff || rsp_ready);
   assign pop         = fire;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Per-level compares against the current indent
   always_comb begin
      new_level = '0;
      for (int l = 0; l < LD; l++) begin
         in_range[l] = (LW'(l) <= level_ff);
         lt_vec[l]   = (stack_ff[l] < indent_ff);
         le_vec[l]   = (stack_ff[l] <= indent_ff);
         eq_vec[l]   = (stack_ff[l] == indent_ff);
         if (in_range[l] && le_vec[l]) begin
            new_level = LW'(l);
         end
      end
      grow = &(lt_vec | ~in_range);
      hit  = |(eq_vec & in_range);
   end

   // Column and byte arithmetic
   assign space_sum = {1'b0, indent_ff} + 13'd1;
   assign tab_sum   = {1'b0, indent_ff} + 13'(ilsp_pkg::TAB_STOP)
                      - 13'(indent_ff % ilsp_pkg::TAB_STOP);
   assign byte_sum  = {1'b0, bytes_ff} + 17'(head_cmd.nbytes);

   // Next state and result
   always_comb begin
      state_in  = state_ff;
      indent_in = indent_ff;
      bytes_in  = bytes_ff;
      level_in  = level_ff;
      stack_in  = stack_ff;
      emit      = 1'b0;
      rsp_in    = '0;
      case (state_ff)
         ilsp_pkg::BK_INDENT: begin
            case (head_cmd.op)
               ilsp_pkg::OP_HDR_BAD: begin
                  emit = 1'b1;
                  rsp_in.status = ilsp_pkg::ST_BAD_HEADER;
                  rsp_in.at_end = 1'b1;
                  state_in = ilsp_pkg::BK_DONE;
               end
               ilsp_pkg::OP_HDR_GARBAGE: begin
                  emit = 1'b1;
                  rsp_in.status = ilsp_pkg::ST_HDR_GARB;
                  rsp_in.at_end = 1'b1;
                  state_in = ilsp_pkg::BK_DONE;
               end
               ilsp_pkg::OP_EOD: begin
                  emit = 1'b1;
                  rsp_in.status = ilsp_pkg::ST_END;
                  rsp_in.at_end = 1'b1;
                  state_in = ilsp_pkg::BK_DONE;
               end
               ilsp_pkg::OP_BAD: begin
                  emit = 1'b1;
                  rsp_in.status = ilsp_pkg::ST_INVALID;
                  rsp_in.at_end = 1'b1;
                  state_in = ilsp_pkg::BK_DONE;
               end
               ilsp_pkg::OP_NEWLINE: begin
                  emit = 1'b1;
                  rsp_in.status = ilsp_pkg::ST_EMPTY;
                  indent_in = '0;
               end
               ilsp_pkg::OP_SPACE: begin
                  indent_in = space_sum[12] ? ilsp_pkg::INDENT_MAX : space_sum[11:0];
               end
               ilsp_pkg::OP_TAB: begin
                  indent_in = tab_sum[12] ? ilsp_pkg::INDENT_MAX : tab_sum[11:0];
               end
               ilsp_pkg::OP_CHAR: begin
                  bytes_in = 16'(head_cmd.nbytes);
                  state_in = ilsp_pkg::BK_TEXT;
                  if (grow) begin
                     // indent grew: push a new level, or report too deep if the stack is full
                     if (level_ff == LW'(LD - 1)) begin
                        emit = 1'b1;
                        rsp_in.status = ilsp_pkg::ST_TOO_DEEP;
                        rsp_in.at_end = 1'b1;
                        state_in = ilsp_pkg::BK_DONE;
                     end else begin
                        level_in = level_ff + LW'(1);
                        for (int l = 0; l < LD; l++) begin
                           if (LW'(l) == level_ff + LW'(1)) begin
                              stack_in[l] = indent_ff;
                           end
                        end
                     end
                  end else if (!hit) begin
                     // dedent landed between two levels
                     emit = 1'b1;
                     rsp_in.status = ilsp_pkg::ST_MISMATCH;
                     rsp_in.at_end = 1'b1;
                     state_in = ilsp_pkg::BK_DONE;
                  end else begin
                     level_in = new_level;
                  end
               end
               default: begin
                  state_in = ilsp_pkg::BK_DONE;
               end
            endcase
         end
         ilsp_pkg::BK_TEXT: begin
            case (head_cmd.op)
               ilsp_pkg::OP_EOD: begin
                  emit = 1'b1;
                  rsp_in.status      = ilsp_pkg::ST_LINE;
                  rsp_in.line_indent = indent_ff;
                  rsp_in.nest_depth  = 4'(level_ff);
                  rsp_in.text_bytes  = bytes_ff;
                  rsp_in.at_end      = 1'b1;
                  state_in = ilsp_pkg::BK_DONE;
               end
               ilsp_pkg::OP_BAD, ilsp_pkg::OP_HDR_BAD, ilsp_pkg::OP_HDR_GARBAGE: begin
                  emit = 1'b1;
                  rsp_in.status = ilsp_pkg::ST_INVALID;
                  rsp_in.at_end = 1'b1;
                  state_in = ilsp_pkg::BK_DONE;
               end
               ilsp_pkg::OP_NEWLINE: begin
                  emit = 1'b1;
                  rsp_in.status      = ilsp_pkg::ST_LINE;
                  rsp_in.line_indent = indent_ff;
                  rsp_in.nest_depth  = 4'(level_ff);
                  rsp_in.text_bytes  = bytes_ff;
                  indent_in = '0;
                  bytes_in  = '0;
                  state_in  = ilsp_pkg::BK_INDENT;
               end
               default: begin
                  // any other character counts as text
                  bytes_in = byte_sum[16] ? ilsp_pkg::BYTES_MAX : byte_sum[15:0];
               end
            endcase
         end
         ilsp_pkg::BK_DONE: begin
            // stream closed: discard
            emit = 1'b0;
         end
         default: begin
            state_in = ilsp_pkg::BK_DONE;
         end
      endcase
   end

   // Output register valid
   always_comb begin
      if (fire && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // Control and stack registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ilsp_pkg::BK_INDENT;
         indent_ff    <= '0;
         bytes_ff     <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         for (int l = 0; l < LD; l++) begin
            stack_ff[l] <= '0;
         end
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (fire) begin
            state_ff  <= state_in;
            indent_ff <= indent_in;
            bytes_ff  <= bytes_in;
            level_ff  <= level_in;
            stack_ff  <= stack_in;
         end
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (fire && emit) begin
         rsp_ff <= rsp_in;
      end
   end

   // Once closed, the back end never reopens
   a_done_sticky: assert property (@(posedge clock) disable iff (reset)
      state_ff == ilsp_pkg::BK_DONE |=> state_ff == ilsp_pkg::BK_DONE)
      else $error("back end left the done state");

   // A closing result always moves the back end to done
   a_end_closes: assert property (@(posedge clock) disable iff (reset)
      fire && emit && rsp_in.at_end |=> state_ff == ilsp_pkg::BK_DONE)
      else $error("closing result without entering done");

   // A pushed level sits strictly above the root indent
   a_level_above_root: assert property (@(posedge clock) disable iff (reset)
      level_ff != '0 |-> stack_ff[1] > stack_ff[0])
      else $error("level stack not increasing");

   // Nothing is taken from the queue while a result is stuck
   a_no_pop_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ready |-> !pop)
      else $error("command consumed while result stalled");

endmodule

FILE: rtl/indent_line_structure_parser_core.sv
// Top level: front end, command queue and back end of the indentation line parser.
// An accepted request is queued as a command; the back end pops it and registers any result.
// Throughput: one request per cycle; the back end retires one queued command per cycle
// while no result is stalled. The front end stalls only when the two-entry command queue is full.
// Reset clears the header position, the level stack, the current level and all counts.
// After an end or error result every later request is accepted and dropped until reset.
module indent_line_structure_parser_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  ilsp_pkg::req_type   req_payload,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output ilsp_pkg::rsp_type   rsp_payload
);

   ilsp_pkg::q_stat_type q_stat;
   ilsp_pkg::cmd_type    push_cmd;
   ilsp_pkg::cmd_type    head_cmd;
   logic                 push;
   logic                 pop;

   ilsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_stat      (q_stat),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   ilsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .q_stat   (q_stat)
   );

   ilsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_stat      (q_stat),
      .head_cmd    (head_cmd),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

FILE: tb/ilsp_line_checker.sv
// Checker for the indentation line parser: predicts each line, empty-line and closing result and compares it.
`timescale 1ns / 1ps

module ilsp_line_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  ilsp_pkg::req_type  req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  ilsp_pkg::rsp_type  rsp_payload,
   output int                 mismatch_count,
   output int                 open_count,
   output int                 lines_checked
);

   typedef enum logic [1:0] {
      PS_HEADER,
      PS_INDENT,
      PS_TEXT,
      PS_DONE
   } parse_state_type;

   // Predicted parser state
   parse_state_type   pstate;
   int                hdr_pos;
   int                col;
   int                nbytes;
   int                level;
   int                level_indent [ilsp_pkg::LEVEL_DEPTH];

   ilsp_pkg::rsp_type expected_lines [$];

   // Queue a closing result with zeroed line fields and stop parsing
   task automatic close_stream(input logic [2:0] status);
      expected_lines.push_back('{status: status, line_indent: '0, nest_depth: '0,
                                 text_bytes: '0, at_end: 1'b1});
      pstate = PS_DONE;
   endtask

   task automatic queue_line(input logic last);
      expected_lines.push_back('{status: ilsp_pkg::ST_LINE, line_indent: col[11:0],
                                 nest_depth: level[3:0], text_bytes: nbytes[15:0],
                                 at_end: last});
   endtask

   // Advance the predicted parser by one request
   task automatic parse_char(input ilsp_pkg::req_type r);
      logic ok;
      logic eod;
      ok  = (r.code_kind == ilsp_pkg::KIND_VALID);
      eod = (r.code_kind == ilsp_pkg::KIND_EOD);
      case (pstate)
         PS_HEADER: begin
            if (hdr_pos >= 1 && hdr_pos <= 4) begin
               if (!ok || r.code_point != ilsp_pkg::MAGIC_CHARS[hdr_pos-1]) begin
                  close_stream(ilsp_pkg::ST_BAD_HEADER);
                  return;
               end
            end else if (hdr_pos == ilsp_pkg::HDR_LEN - 1) begin
               if (!ok || r.code_point != ilsp_pkg::CH_NEWLINE) begin
                  close_stream(ilsp_pkg::ST_HDR_GARB);
                  return;
               end
            end else if (eod) begin
               close_stream(hdr_pos == 0 ? ilsp_pkg::ST_BAD_HEADER : ilsp_pkg::ST_HDR_GARB);
               return;
            end
            hdr_pos++;
            if (hdr_pos == ilsp_pkg::HDR_LEN) pstate = PS_INDENT;
         end
         PS_INDENT: begin
            if (eod) begin
               close_stream(ilsp_pkg::ST_END);
            end else if (!ok) begin
               close_stream(ilsp_pkg::ST_INVALID);
            end else if (r.code_point == ilsp_pkg::CH_NEWLINE) begin
               col = 0;
               expected_lines.push_back('{status: ilsp_pkg::ST_EMPTY, line_indent: '0,
                                          nest_depth: '0, text_bytes: '0, at_end: 1'b0});
            end else if (r.code_point == ilsp_pkg::CH_SPACE) begin
               col = col + 1;
               if (col > ilsp_pkg::INDENT_MAX) col = ilsp_pkg::INDENT_MAX;
            end else if (r.code_point == ilsp_pkg::CH_TAB) begin
               col = col + ilsp_pkg::TAB_STOP - (col % ilsp_pkg::TAB_STOP);
               if (col > ilsp_pkg::INDENT_MAX) col = ilsp_pkg::INDENT_MAX;
            end else begin
               // First text character: settle the line's level
               if (col > level_indent[level]) begin
                  if (level >= ilsp_pkg::LEVEL_DEPTH - 1) begin
                     close_stream(ilsp_pkg::ST_TOO_DEEP);
                     return;
                  end
                  level++;
                  level_indent[level] = col;
               end else if (col < level_indent[level]) begin
                  while (level > 0 && col < level_indent[level]) level--;
                  if (col != level_indent[level]) begin
                     close_stream(ilsp_pkg::ST_MISMATCH);
                     return;
                  end
               end
               nbytes = r.code_bytes;
               pstate = PS_TEXT;
            end
         end
         PS_TEXT: begin
            if (eod) begin
               queue_line(1'b1);
               pstate = PS_DONE;
            end else if (!ok) begin
               close_stream(ilsp_pkg::ST_INVALID);
            end else if (r.code_point == ilsp_pkg::CH_NEWLINE) begin
               queue_line(1'b0);
               col    = 0;
               nbytes = 0;
               pstate = PS_INDENT;
            end else begin
               nbytes = nbytes + r.code_bytes;
               if (nbytes > ilsp_pkg::BYTES_MAX) nbytes = ilsp_pkg::BYTES_MAX;
            end
         end
         default: ;
      endcase
   endtask

   // Compare one delivered result with the oldest prediction
   task automatic check_line(input ilsp_pkg::rsp_type got);
      ilsp_pkg::rsp_type want;
      if (expected_lines.size() == 0) begin
         $display("%0t: unexpected result, expected none, got %p", $time, got);
         mismatch_count++;
         return;
      end
      want = expected_lines.pop_front();
      lines_checked++;
      if (got.status != want.status) begin
         $display("%0t: status expected %0d got %0d", $time, want.status, got.status);
         mismatch_count++;
      end
      if (got.line_indent != want.line_indent) begin
         $display("%0t: line_indent expected %0d got %0d", $time,
                  want.line_indent, got.line_indent);
         mismatch_count++;
      end
      if (got.nest_depth != want.nest_depth) begin
         $display("%0t: nest_depth expected %0d got %0d", $time,
                  want.nest_depth, got.nest_depth);
         mismatch_count++;
      end
      if (got.text_bytes != want.text_bytes) begin
         $display("%0t: text_bytes expected %0d got %0d", $time,
                  want.text_bytes, got.text_bytes);
         mismatch_count++;
      end
      if (got.at_end != want.at_end) begin
         $display("%0t: at_end expected %0d got %0d", $time, want.at_end, got.at_end);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         pstate  = PS_HEADER;
         hdr_pos = 0;
         col     = 0;
         nbytes  = 0;
         level   = 0;
         foreach (level_indent[i]) level_indent[i] = 0;
         expected_lines.delete();
         mismatch_count = 0;
         lines_checked  = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_line(rsp_payload);
         if (req_valid && req_ready) parse_char(req_payload);
      end
      open_count = expected_lines.size();
   end

endmodule

FILE: tb/tb_indent_line_structure_parser_core.sv
// Testbench top: drives character streams into the indentation line parser and reports.
`timescale 1ns / 1ps

module tb_indent_line_structure_parser_core;

   localparam logic [1:0]  KIND_BAD    = 2'd1;
   localparam logic [1:0]  KIND_SPARE  = 2'd3;
   localparam logic [20:0] CP_TOP      = 21'h10FFFF;
   localparam int          CHAR_TARGET = 1900;
   localparam int          QUIET_LIMIT = 3000;
   localparam int          STALL_LEN   = 300;

   localparam int MIX_SLOW_SINK = 0;
   localparam int MIX_SLOW_SRC  = 1;
   localparam int MIX_FULL      = 2;

   localparam int END_EOD_LINE_START = 0;
   localparam int END_EOD_IN_TEXT    = 1;
   localparam int END_INVALID        = 2;
   localparam int END_SPARE_KIND     = 3;
   localparam int END_MISMATCH       = 4;
   localparam int END_TOO_DEEP       = 5;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_ready;
   ilsp_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready   = 1'b0;
   ilsp_pkg::rsp_type rsp_payload;

   int mismatch_count;
   int open_count;
   int lines_checked;

   int idle_mix      = MIX_SLOW_SINK;
   int stall_request = 0;
   int stall_seen    = 0;
   int stall_left    = 0;
   int quiet_cycles  = 0;
   int sent_count    = 0;
   int open_levels [$];

   always #4 clock = ~clock;

   indent_line_structure_parser_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   ilsp_line_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_payload    (req_payload),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_payload    (rsp_payload),
      .mismatch_count (mismatch_count),
      .open_count     (open_count),
      .lines_checked  (lines_checked)
   );

   // Result sink: random back-pressure per mix, plus a long hold on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else if (stall_request != stall_seen) begin
         stall_seen = stall_request;
         stall_left = STALL_LEN;
         rsp_ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         case (idle_mix)
            MIX_SLOW_SINK: rsp_ready <= ($urandom_range(0, 99) >= 50);
            MIX_SLOW_SRC:  rsp_ready <= ($urandom_range(0, 99) >= 6);
            default:       rsp_ready <= 1'b1;
         endcase
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
         $display("tb_indent_line_structure_parser_core: FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Offer one request and hold it until accepted
   task automatic send_char(input logic [20:0] cp, input logic [2:0] nb,
                            input logic [1:0] kind);
      int idle_pct;
      idle_pct = (idle_mix == MIX_SLOW_SINK) ? 6 : (idle_mix == MIX_SLOW_SRC) ? 50 : 0;
      while ($urandom_range(0, 99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{code_point: cp, code_bytes: nb, code_kind: kind};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic put_char(input logic [20:0] cp);
      send_char(cp, 3'($urandom_range(1, 4)), ilsp_pkg::KIND_VALID);
   endtask

   function automatic logic [20:0] text_cp(input bit first);
      logic [20:0] cp;
      do begin
         case ($urandom_range(0, 5))
            0, 1:    cp = 21'($urandom_range(33, 126));
            2:       cp = 21'($urandom_range(0, CP_TOP));
            3:       cp = $urandom_range(0, 1) ? 21'd0 : CP_TOP;
            4:       cp = ilsp_pkg::CH_SPACE;
            default: cp = ilsp_pkg::CH_TAB;
         endcase
      end while (cp == ilsp_pkg::CH_NEWLINE ||
                 (first && (cp == ilsp_pkg::CH_SPACE || cp == ilsp_pkg::CH_TAB)));
      return cp;
   endfunction

   // Random mix of spaces and tabs that lands exactly on the target column
   task automatic emit_indent(input int target);
      int c;
      int step;
      c = 0;
      while (c < target) begin
         step = ilsp_pkg::TAB_STOP - (c % ilsp_pkg::TAB_STOP);
         if (c + step <= target && $urandom_range(0, 1)) begin
            put_char(ilsp_pkg::CH_TAB);
            c += step;
         end else begin
            put_char(ilsp_pkg::CH_SPACE);
            c += 1;
         end
      end
   endtask

   task automatic emit_text(input int n);
      put_char(text_cp(1'b1));
      repeat (n - 1) put_char(text_cp(1'b0));
   endtask

   // Full line at a legal indent; keeps the local copy of open levels in step
   task automatic emit_line(input int target, input int n);
      while (open_levels[$] > target) void'(open_levels.pop_back());
      if (open_levels[$] < target) open_levels.push_back(target);
      emit_indent(target);
      emit_text(n);
      put_char(ilsp_pkg::CH_NEWLINE);
   endtask

   task automatic climb_to_max_depth();
      emit_line(0, $urandom_range(1, 3));
      while (open_levels.size() < ilsp_pkg::LEVEL_DEPTH) emit_line(open_levels[$] + 1, 1);
   endtask

   // One line whose indent runs past the column limit, between two lines at column zero
   task automatic emit_saturated_line();
      emit_line(0, 1);
      open_levels.push_back(ilsp_pkg::INDENT_MAX);
      repeat (515) put_char(ilsp_pkg::CH_TAB);
      repeat (3) put_char(ilsp_pkg::CH_SPACE);
      emit_text($urandom_range(1, 4));
      put_char(ilsp_pkg::CH_NEWLINE);
      emit_line(0, 2);
   endtask

   task automatic emit_random_line();
      int pick;
      int top;
      int target;
      int n;
      pick = $urandom_range(0, 99);
      top  = open_levels[$];
      if (pick < 8) begin
         emit_indent($urandom_range(0, 20));
         put_char(ilsp_pkg::CH_NEWLINE);
      end else if (pick < 10) begin
         climb_to_max_depth();
      end else begin
         case ($urandom_range(0, 2))
            0: target = top;
            1: target = (open_levels.size() < ilsp_pkg::LEVEL_DEPTH &&
                         top + 12 <= ilsp_pkg::INDENT_MAX)
                        ? top + $urandom_range(1, 12) : top;
            default: target = open_levels[$urandom_range(0, open_levels.size() - 1)];
         endcase
         n = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 60) : $urandom_range(1, 10);
         emit_line(target, n);
      end
   endtask

   // Close the stream in one of the ways the parser distinguishes
   task automatic emit_ending(input int ending);
      logic [1:0] bad_kind;
      case (ending)
         END_EOD_LINE_START: begin
            repeat ($urandom_range(0, 3)) put_char(ilsp_pkg::CH_SPACE);
            send_char(text_cp(1'b0), 3'($urandom_range(1, 4)), ilsp_pkg::KIND_EOD);
         end
         END_EOD_IN_TEXT: begin
            emit_indent(open_levels[$]);
            emit_text($urandom_range(1, 6));
            send_char(text_cp(1'b0), 3'($urandom_range(1, 4)), ilsp_pkg::KIND_EOD);
         end
         END_INVALID, END_SPARE_KIND: begin
            bad_kind = (ending == END_INVALID) ? KIND_BAD : KIND_SPARE;
            if ($urandom_range(0, 1)) begin
               emit_indent($urandom_range(0, open_levels[$]));
            end else begin
               emit_indent(open_levels[$]);
               emit_text($urandom_range(1, 6));
            end
            send_char(21'($urandom_range(0, CP_TOP)), 3'($urandom_range(1, 4)), bad_kind);
         end
         END_MISMATCH: begin
            emit_line(0, 1);
            emit_line(4, 1);
            emit_indent(2);
            put_char(text_cp(1'b1));
         end
         default: begin
            climb_to_max_depth();
            emit_indent(open_levels[$] + 1);
            put_char(text_cp(1'b1));
         end
      endcase
   endtask

   initial begin
      int ending;
      bit sat_done;
      bit stall_done;
      string ending_name;

      sat_done   = 1'b0;
      stall_done = 1'b0;
      open_levels.push_back(0);
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: header with odd free characters, then basic line shapes
      send_char(CP_TOP, 3'd4, KIND_BAD);
      for (int i = 0; i < 4; i++) begin
         send_char(ilsp_pkg::MAGIC_CHARS[i], 3'd1, ilsp_pkg::KIND_VALID);
      end
      send_char(21'd0, 3'd1, KIND_SPARE);
      send_char(21'd0, 3'd1, ilsp_pkg::KIND_VALID);
      send_char(CP_TOP, 3'd4, ilsp_pkg::KIND_VALID);
      send_char(ilsp_pkg::CH_TAB, 3'd2, KIND_BAD);
      send_char(ilsp_pkg::CH_NEWLINE, 3'd1, ilsp_pkg::KIND_VALID);
      emit_line(0, 1);
      put_char(ilsp_pkg::CH_NEWLINE);
      emit_line(ilsp_pkg::TAB_STOP, 2);
      put_char(ilsp_pkg::CH_SPACE);
      put_char(ilsp_pkg::CH_TAB);
      put_char(CP_TOP);
      put_char(ilsp_pkg::CH_NEWLINE);
      put_char(ilsp_pkg::CH_SPACE);
      put_char(ilsp_pkg::CH_SPACE);
      put_char(ilsp_pkg::CH_NEWLINE);
      emit_line(0, 1);

      // Random well-formed lines under the three idle mixes
      while (sent_count < CHAR_TARGET) begin
         if (sent_count < CHAR_TARGET / 3) begin
            idle_mix = MIX_SLOW_SINK;
         end else if (sent_count < 2 * CHAR_TARGET / 3) begin
            idle_mix = MIX_SLOW_SRC;
         end else begin
            idle_mix = MIX_FULL;
            if (!stall_done) begin
               stall_done = 1'b1;
               stall_request++;
            end
         end
         if (!sat_done && sent_count >= CHAR_TARGET / 2) begin
            sat_done = 1'b1;
            emit_saturated_line();
         end
         emit_random_line();
      end

      ending = $urandom_range(END_EOD_LINE_START, END_TOO_DEEP);
      case (ending)
         END_EOD_LINE_START: ending_name = "end of data at a line start";
         END_EOD_IN_TEXT:    ending_name = "end of data inside a line";
         END_INVALID:        ending_name = "an invalid byte sequence";
         END_SPARE_KIND:     ending_name = "the unused input kind";
         END_MISMATCH:       ending_name = "a dedent to an unknown level";
         default:            ending_name = "a push past the deepest level";
      endcase
      emit_ending(ending);

      // Everything after the close must be dropped silently
      repeat (10) begin
         send_char(21'($urandom_range(0, CP_TOP)), 3'($urandom_range(1, 4)),
                   2'($urandom_range(0, 3)));
      end
      req_valid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
      repeat (8) @(posedge clock);

      $display("run: %0d characters sent, %0d results checked, idle mixes and a %0d-cycle hold",
               sent_count, lines_checked, STALL_LEN);
      $display("run: stream closed by %s", ending_name);
      if (mismatch_count == 0 && open_count == 0) begin
         $display("tb_indent_line_structure_parser_core: PASS");
      end else begin
         $display("tb_indent_line_structure_parser_core: FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
rtl/ilsp_pkg.sv
rtl/ilsp_front.sv
rtl/ilsp_queue.sv
rtl/ilsp_back.sv
rtl/indent_line_structure_parser_core.sv
tb/ilsp_line_checker.sv
tb/tb_indent_line_structure_parser_core.sv
